// ===== rtl/core/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// scl_pkg: shared definitions for the serial command line parser
// Command codes, character constants, the per-line parse state and the
// first-letter decoder.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int LINE_MAX_DEF   = 32;
  localparam int ADDR_CHARS_DEF = 5;

  localparam int POS_W  = 6;
  localparam int ADDR_W = 16;
  localparam int CODE_W = 3;

  localparam logic [CODE_W-1:0] CODE_EMPTY   = 3'd0;
  localparam logic [CODE_W-1:0] CODE_TEST    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_LAST    = 3'd2;
  localparam logic [CODE_W-1:0] CODE_VERSION = 3'd3;
  localparam logic [CODE_W-1:0] CODE_CLEAR   = 3'd4;
  localparam logic [CODE_W-1:0] CODE_READ    = 3'd5;
  localparam logic [CODE_W-1:0] CODE_WRITE   = 3'd6;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 3'd7;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_DIG0  = 8'h30;
  localparam logic [7:0] CHAR_DIG9  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_W     = 8'h57;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] cmd;
    logic [ADDR_W-1:0] addr;
    logic              tail;
    logic              ended;
  } scl_state_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] addr;
    logic              have;
  } scl_result_t;

  function automatic logic [CODE_W-1:0] decode_first(input logic [7:0] b);
    logic [7:0] u;
    logic [CODE_W-1:0] code;
    u = b;
    if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) u = b & ~CASE_BIT;
    case (u)
      CHAR_T:  code = CODE_TEST;
      CHAR_L:  code = CODE_LAST;
      CHAR_V:  code = CODE_VERSION;
      CHAR_C:  code = CODE_CLEAR;
      CHAR_R:  code = CODE_READ;
      CHAR_W:  code = CODE_WRITE;
      default: code = CODE_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/serial_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_parser: serial command line decoder
// Collects received bytes into lines and emits one decoded command per line.
// ----------------------------------------------------------------------------
// Usage: present one received byte per request on in_rx_byte. Every byte
// except a carriage return is absorbed into the current line and gives no
// result; a carriage return gives exactly one result with the command code
// (selected by the first byte, case-insensitive), the decimal address taken
// from line positions 1 to ADDR_CHARS for read and write, and have_address
// for a read that has anything after its letter. A zero byte ends the line
// content early; a line that reaches LINE_MAX bytes drops the next byte and
// restarts. Rate: one byte per clock cycle sustained while the result side
// is not stalling. A carriage return accepted into the input register is
// parsed from there and lands in the result register once that register is
// free, which raises out_valid; the result then stays until out_ready takes
// it, with its fields unchanged. A result that waits on out_ready holds
// the input register, and a byte waiting there holds in_ready low. The parse
// state is a single register updated as the input register drains, so
// back-to-back bytes see each other's effect without bubbles.
module serial_command_line_parser #(
  parameter int LINE_MAX   = scl_pkg::LINE_MAX_DEF,
  parameter int ADDR_CHARS = scl_pkg::ADDR_CHARS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [scl_pkg::CODE_W-1:0] out_command_code,
  output logic [scl_pkg::ADDR_W-1:0] out_address,
  output logic                       out_have_address
);
  import scl_pkg::*;

  // input register
  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [7:0] in_byte_r;

  // line state
  scl_state_t st_r;
  scl_state_t st_nxt;

  // result register
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic [CODE_W-1:0] out_code_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_have_r;

  scl_result_t res;
  logic        out_free;
  logic        s1_go;

  scl_parse #(
    .LINE_MAX   (LINE_MAX),
    .ADDR_CHARS (ADDR_CHARS)
  ) u_parse (
    .rx_byte (in_byte_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  // the result register can take a new value when empty or being drained
  assign out_free = !out_vld_r || out_ready;
  // advance the held byte through the parser
  assign s1_go    = in_vld_r && out_free;
  assign in_ready = !in_vld_r || s1_go;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ready) in_vld_nxt = in_valid;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_go) begin
      out_vld_nxt = res.valid;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      // hold the line state unless a byte goes through
      if (s1_go) st_r <= st_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_byte_r <= in_rx_byte;
    if (s1_go && res.valid) begin
      out_code_r <= res.code;
      out_addr_r <= res.addr;
      out_have_r <= res.have;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_command_code = out_code_r;
  assign out_address      = out_addr_r;
  assign out_have_address = out_have_r;

endmodule

// ===== rtl/core/scl_parse.sv =====
// ----------------------------------------------------------------------------
// scl_parse: per-byte line parser
// Next line state and the decoded command for one received byte.
// ----------------------------------------------------------------------------
module scl_parse #(
  parameter int LINE_MAX   = scl_pkg::LINE_MAX_DEF,
  parameter int ADDR_CHARS = scl_pkg::ADDR_CHARS_DEF
) (
  input  logic [7:0]          rx_byte,
  input  scl_pkg::scl_state_t st,
  output scl_pkg::scl_state_t st_nxt,
  output scl_pkg::scl_result_t res
);
  import scl_pkg::*;

  localparam logic [POS_W-1:0] LineMaxC   = POS_W'(LINE_MAX);
  localparam logic [POS_W-1:0] AddrCharsC = POS_W'(ADDR_CHARS);

  scl_state_t        clr;
  logic              is_digit;
  logic              addr_cmd;
  logic [ADDR_W-1:0] addr_mac;

  assign clr      = '0;
  assign is_digit = (rx_byte >= CHAR_DIG0) && (rx_byte <= CHAR_DIG9);
  assign addr_cmd = (st.cmd == CODE_READ) || (st.cmd == CODE_WRITE);
  // times ten as two shifts and an add
  assign addr_mac = (st.addr << 3) + (st.addr << 1)
                    + ADDR_W'(rx_byte[3:0]);

  always_comb begin
    res    = '0;
    st_nxt = st;
    if (rx_byte == CHAR_CR) begin
      res.valid = 1'b1;
      res.code  = st.cmd;
      if (st.cmd == CODE_READ) begin
        if (st.tail) begin
          res.addr = st.addr;
          res.have = 1'b1;
        end
      end else if (st.cmd == CODE_WRITE) begin
        res.addr = st.addr;
      end
      st_nxt = clr;
    end else if (st.pos >= LineMaxC) begin
      // overlong line: drop the byte, restart
      st_nxt = clr;
    end else begin
      if (!st.ended) begin
        if (rx_byte == CHAR_NUL) begin
          st_nxt.ended = 1'b1;
        end else if (st.pos == '0) begin
          st_nxt.cmd = decode_first(rx_byte);
        end else begin
          if (st.pos == POS_W'(1)) st_nxt.tail = 1'b1;
          if (addr_cmd && st.pos <= AddrCharsC && is_digit) st_nxt.addr = addr_mac;
        end
      end
      st_nxt.pos = st.pos + POS_W'(1);
    end
  end

endmodule

// ===== rtl/core/scl_checker.sv =====
// ----------------------------------------------------------------------------
// scl_checker: port-level checks for the serial command line parser
// Watches the result channel and the result fields over time.
// ----------------------------------------------------------------------------
module scl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [scl_pkg::CODE_W-1:0] out_command_code,
  input logic [scl_pkg::ADDR_W-1:0] out_address,
  input logic                       out_have_address
);
  import scl_pkg::*;

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command_code)
      && $stable(out_address) && $stable(out_have_address))
    else $error("stalled result changed");

  // have_address only on a read
  a_have_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_have_address |-> out_command_code == CODE_READ)
    else $error("have_address on a non-read command");

  // address is zero unless read or write, and zero on a read without tail
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_code != CODE_WRITE && !out_have_address
      |-> out_address == '0)
    else $error("address set where none is due");

endmodule

bind serial_command_line_parser scl_checker u_scl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_command_code (out_command_code),
  .out_address      (out_address),
  .out_have_address (out_have_address)
);
